/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers shared by the core modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

/* rtl/core/nqpc_pkg.sv */
// ----------------------------------------------------------------------------
// nqpc_pkg
// shared types and constants of the n-queens prefix counter
// ----------------------------------------------------------------------------
package nqpc_pkg;

  localparam int PREFIX_ROWS = 3;
  localparam int BOARD_MIN   = 4;
  localparam int COL_W       = 4;
  localparam int BSIZE_W     = 5;
  localparam int COUNT_W     = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX        = 24'hFFFFFF;
  localparam logic [BSIZE_W-1:0] BOARD_SIZE_RESET = 5'd14;

  // register index decoded from paddr[2]
  localparam logic REG_BOARD_SIZE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } nqpc_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic write_result;
  } nqpc_cmd_t;

  typedef struct packed {
    logic search_done;
  } nqpc_status_t;

endpackage

/* rtl/core/nqpc_ctrl.sv */
// ----------------------------------------------------------------------------
// nqpc_ctrl
// sequencer: takes a prefix, runs the search one node a cycle, posts result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nqpc_ctrl
  import nqpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  logic         m_tready,
  output nqpc_cmd_t    cmd,
  input  nqpc_status_t status
);

  nqpc_state_t state, state_next;
  logic        out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.search_done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FINISH: begin
        // wait for room in the output register
        if (out_free) begin
          cmd.write_result = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.write_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `ASSERT_PROP(a_accept_starts_search, clk, rst,
    ((s_tvalid && s_tready) |=> (state == ST_SEARCH)))
  `ASSERT_PROP(a_result_posted, clk, rst,
    (cmd.write_result |=> m_tvalid))
  `ASSERT_NEVER(a_step_when_done, clk, rst, (cmd.step && status.search_done))

endmodule

/* rtl/core/nqpc_datapath.sv */
// ----------------------------------------------------------------------------
// nqpc_datapath
// bitmask backtracking datapath with a per-row stack and saturating tally
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nqpc_datapath
  import nqpc_pkg::*;
#(
  parameter int MAX_N = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [BSIZE_W-1:0] board_size,
  input  logic [COL_W-1:0]   first_column,
  input  logic [COL_W-1:0]   second_column,
  input  logic [COL_W-1:0]   third_column,
  input  nqpc_cmd_t          cmd,
  output nqpc_status_t       status,
  output logic [COUNT_W-1:0] solution_count
);

  localparam int RW = $clog2(MAX_N);
  localparam int NW = $clog2(MAX_N + 1);

  typedef logic [MAX_N-1:0] mask_t;

  // stack of saved row state, read only at row - 1
  mask_t stack_free  [MAX_N];
  mask_t stack_cols  [MAX_N];
  mask_t stack_left  [MAX_N];
  mask_t stack_right [MAX_N];

  mask_t              free, cols, left, right, full;
  logic [RW-1:0]      current_row;
  logic [NW-1:0]      n_reg;
  logic [COUNT_W-1:0] solution_tally;

  // prefix setup
  logic [5:0]    n_clamp;
  mask_t         full_next, b0, b1, b2, pcols, pleft, pright;
  logic          prefix_bad;

  always_comb begin
    if ({1'b0, board_size} < 6'(BOARD_MIN)) begin
      n_clamp = 6'(BOARD_MIN);
    end else if ({1'b0, board_size} > 6'(MAX_N)) begin
      n_clamp = 6'(MAX_N);
    end else begin
      n_clamp = {1'b0, board_size};
    end
    for (int i = 0; i < MAX_N; i++) begin
      full_next[i] = (6'(i) < n_clamp);
    end
    b0     = mask_t'(1) << first_column;
    b1     = mask_t'(1) << second_column;
    b2     = mask_t'(1) << third_column;
    pcols  = b0 | b1 | b2;
    pleft  = ((b0 << 3) | (b1 << 2) | (b2 << 1)) & full_next;
    pright = (b0 >> 3) | (b1 >> 2) | (b2 >> 1);
    prefix_bad = ({2'b00, first_column} >= n_clamp) ||
                 ({2'b00, second_column} >= n_clamp) ||
                 ({2'b00, third_column} >= n_clamp);
  end

  // one search step
  mask_t         pick, nc, nl, nr;
  logic          last_row;
  logic [RW-1:0] prev_row;

  always_comb begin
    pick     = free & (~free + mask_t'(1));
    nc       = cols | pick;
    nl       = ((left | pick) << 1) & full;
    nr       = (right | pick) >> 1;
    last_row = ((NW'(current_row) + NW'(1)) == n_reg);
    prev_row = current_row - RW'(1);
  end

  assign status.search_done = (free == '0) && (current_row == RW'(PREFIX_ROWS));

  always_ff @(posedge clk) begin
    if (rst) begin
      current_row    <= RW'(PREFIX_ROWS);
      solution_tally <= '0;
      free           <= '0;
    end else if (cmd.load) begin
      current_row    <= RW'(PREFIX_ROWS);
      solution_tally <= '0;
      // an off-board prefix leaves nothing to search, so the count stays zero
      free           <= prefix_bad ? '0 : (full_next & ~(pcols | pleft | pright));
    end else if (cmd.step) begin
      if (free == '0) begin
        // backtrack to the parent row
        current_row <= prev_row;
        free        <= stack_free[prev_row];
      end else if (last_row) begin
        free <= free ^ pick;
        if (solution_tally != COUNT_MAX) begin
          solution_tally <= solution_tally + COUNT_W'(1);
        end
      end else begin
        current_row <= current_row + RW'(1);
        free        <= full & ~(nc | nl | nr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cols  <= pcols;
      left  <= pleft;
      right <= pright;
      full  <= full_next;
      n_reg <= NW'(n_clamp);
    end else if (cmd.step) begin
      if (free == '0) begin
        cols  <= stack_cols[prev_row];
        left  <= stack_left[prev_row];
        right <= stack_right[prev_row];
      end else if (!last_row) begin
        stack_free[current_row]  <= free ^ pick;
        stack_cols[current_row]  <= cols;
        stack_left[current_row]  <= left;
        stack_right[current_row] <= right;
        cols  <= nc;
        left  <= nl;
        right <= nr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_result) begin
      solution_count <= solution_tally;
    end
  end

  `ASSERT_PROP(a_row_in_range, clk, rst,
    (cmd.step |-> ((current_row >= RW'(PREFIX_ROWS)) && (NW'(current_row) < n_reg))))
  `ASSERT_PROP(a_tally_monotonic, clk, rst,
    (cmd.step |=> (solution_tally >= $past(solution_tally))))
  `ASSERT_NEVER(a_pick_not_onehot, clk, rst, (cmd.step && (free != '0) && !$onehot(pick)))

endmodule

/* rtl/core/nqueens_prefix_counter_core.sv */
// ----------------------------------------------------------------------------
// nqueens_prefix_counter_core
// counts n-queens completions of a three-row prefix by backtracking search
// ----------------------------------------------------------------------------
// usage:
//   s_tvalid/s_tready/s_tdata carries one prefix per transaction, the queen
//   columns of rows zero, one and two. m_tvalid/m_tready/m_tdata returns one
//   24-bit saturating solution count per prefix, in order.
//   board_size is written through the apb port at address 0 (reset 14) and
//   is clamped to 4..MAX_N. the user writes it only while no prefix is in
//   flight; the block itself does not enforce this.
// sequence:
//   the prefix is loaded, then the search runs one step per cycle (each step
//   either places a queen or backtracks one row), then the end of the search
//   is seen and the result is posted. the single shared step unit and its row
//   stack set the search rate. an off-board prefix returns 0 with no search.
//   a new prefix is taken only between searches.
// reset:
//   synchronous rst clears the sequencer, the output valid flag and the
//   tally, and sets board_size to 14.
// stall:
//   a finished count waits in the output register; the next prefix is still
//   taken and searched, and only the next result write waits for m_tready.
// ----------------------------------------------------------------------------
module nqueens_prefix_counter_core
  import nqpc_pkg::*;
#(
  parameter int MAX_N = 16
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // prefix input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // first_column[3:0], second_column[7:4],
                                // third_column[11:8], zero[15:12]
  // count output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // solution_count[23:0]
);

  logic [BSIZE_W-1:0] board_size;
  nqpc_cmd_t          cmd;
  nqpc_status_t       status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_size <= BOARD_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BOARD_SIZE)) begin
      board_size <= pwdata[BSIZE_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_BOARD_SIZE) begin
      prdata = {{(32-BSIZE_W){1'b0}}, board_size};
    end else begin
      prdata = '0;
    end
  end

  nqpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  nqpc_datapath #(
    .MAX_N (MAX_N)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .board_size     (board_size),
    .first_column   (s_tdata[3:0]),
    .second_column  (s_tdata[7:4]),
    .third_column   (s_tdata[11:8]),
    .cmd            (cmd),
    .status         (status),
    .solution_count (m_tdata)
  );

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for nqueens_prefix_counter_core: prefixes go in through
// a randomly idling stream driver, every count is predicted by a local
// backtracking search and compared in order by a randomly stalling monitor,
// board_size is reprogrammed over apb between idle phases
// ----------------------------------------------------------------------------
module tb;
  import nqpc_pkg::*;

  localparam int MAX_BOARD = 16;
  localparam int LONG_HOLD = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;  // first_column[3:0], second_column[7:4],
                              // third_column[11:8], zero[15:12]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;       // solution_count[23:0]

  logic [15:0]        prefix_q[$];
  logic [COUNT_W-1:0] count_q[$];
  logic [BSIZE_W-1:0] cfg_board_size = BOARD_SIZE_RESET;
  logic [COUNT_W-1:0] want_count;

  int  errors = 0;
  bit  calm = 1'b0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  hold_reqs = 0;
  int  holds_served = 0;

  nqueens_prefix_counter_core #(.MAX_N(MAX_BOARD)) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic int eff_size(input logic [BSIZE_W-1:0] size_reg);
    if (size_reg < BOARD_MIN) return BOARD_MIN;
    if (size_reg > MAX_BOARD) return MAX_BOARD;
    return int'(size_reg);
  endfunction

  // depth-first search over rows below the prefix, one bitmask set per row
  function automatic logic [COUNT_W-1:0] count_completions(
    input logic [BSIZE_W-1:0] size_reg,
    input logic [15:0]        prefix
  );
    int                 n;
    int                 row;
    bit                 searching;
    logic [31:0]        full;
    logic [31:0]        pick;
    logic [31:0]        qbit;
    logic [31:0]        open_at[0:MAX_BOARD];
    logic [31:0]        cols_at[0:MAX_BOARD];
    logic [31:0]        left_at[0:MAX_BOARD];
    logic [31:0]        right_at[0:MAX_BOARD];
    logic [COUNT_W-1:0] tally;
    n = eff_size(size_reg);
    full = (32'd1 << n) - 32'd1;
    tally = '0;
    cols_at[PREFIX_ROWS] = '0;
    left_at[PREFIX_ROWS] = '0;
    right_at[PREFIX_ROWS] = '0;
    for (int i = 0; i < PREFIX_ROWS; i++) begin
      if (prefix[i*COL_W +: COL_W] >= n) return '0;
      qbit = 32'd1 << prefix[i*COL_W +: COL_W];
      cols_at[PREFIX_ROWS] = cols_at[PREFIX_ROWS] | qbit;
      left_at[PREFIX_ROWS] = ((left_at[PREFIX_ROWS] | qbit) << 1) & full;
      right_at[PREFIX_ROWS] = (right_at[PREFIX_ROWS] | qbit) >> 1;
    end
    open_at[PREFIX_ROWS] = full & ~(cols_at[PREFIX_ROWS] | left_at[PREFIX_ROWS] |
                                    right_at[PREFIX_ROWS]);
    row = PREFIX_ROWS;
    searching = 1'b1;
    while (searching) begin
      if (open_at[row] == '0) begin
        if (row == PREFIX_ROWS) searching = 1'b0;
        else row = row - 1;
      end else begin
        pick = open_at[row] & (~open_at[row] + 32'd1);
        open_at[row] = open_at[row] ^ pick;
        if (row + 1 == n) begin
          if (tally != COUNT_MAX) tally = tally + 1'b1;
        end else begin
          cols_at[row+1] = cols_at[row] | pick;
          left_at[row+1] = ((left_at[row] | pick) << 1) & full;
          right_at[row+1] = (right_at[row] | pick) >> 1;
          open_at[row+1] = full & ~(cols_at[row+1] | left_at[row+1] | right_at[row+1]);
          row = row + 1;
        end
      end
    end
    return tally;
  endfunction

  // mostly no idling, sometimes a short gap, rarely a long stretch, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  // prefix driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        count_q.push_back(count_completions(cfg_board_size, s_tdata));
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (prefix_q.size() != 0) begin
          s_tdata <= prefix_q.pop_front();
          s_tvalid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // count monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (count_q.size() == 0) begin
          report_mismatch("count with no prefix pending", m_tdata, '0);
        end else begin
          want_count = count_q.pop_front();
          if (m_tdata !== want_count) report_mismatch("solution_count", m_tdata, want_count);
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (holds_served != hold_reqs) begin
        holds_served <= holds_served + 1;
        hold_left <= LONG_HOLD;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  // checked away from the rising edge so the driver's updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (prefix_q.size() != 0 || s_tvalid || count_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_board_size(input logic [BSIZE_W-1:0] value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_BOARD_SIZE, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_board_size = value;
  endtask

  task automatic push_prefix(input int c0, input int c1, input int c2);
    prefix_q.push_back({4'b0000, 4'(c2), 4'(c1), 4'(c0)});
  endtask

  function automatic bit attacks(input int ra, input int ca, input int rb, input int cb);
    return (ca == cb) || (ca - cb == ra - rb) || (cb - ca == ra - rb);
  endfunction

  // mostly legal prefixes on the current board, the rest arbitrary columns
  task automatic add_random(input int n_items);
    int n;
    int c0;
    int c1;
    int c2;
    int tries;
    bit legal;
    n = eff_size(cfg_board_size);
    for (int k = 0; k < n_items; k++) begin
      legal = 1'b0;
      if ($urandom_range(0, 9) < 7) begin
        tries = 0;
        while (!legal && tries < 50) begin
          c0 = $urandom_range(0, n - 1);
          c1 = $urandom_range(0, n - 1);
          c2 = $urandom_range(0, n - 1);
          legal = !attacks(0, c0, 1, c1) && !attacks(0, c0, 2, c2) && !attacks(1, c1, 2, c2);
          tries++;
        end
      end
      if (!legal) begin
        c0 = $urandom_range(0, 15);
        c1 = $urandom_range(0, 15);
        c2 = $urandom_range(0, 15);
      end
      push_prefix(c0, c1, c2);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset board size, one real search and each column off the board
    calm = 1'b0;
    push_prefix(0, 2, 4);
    push_prefix(15, 0, 0);
    push_prefix(0, 14, 0);
    push_prefix(0, 0, 15);

    write_board_size(5'd4);
    push_prefix(1, 3, 0);
    push_prefix(2, 0, 3);
    push_prefix(0, 0, 0);
    push_prefix(3, 3, 3);
    push_prefix(4, 0, 0);
    push_prefix(0, 4, 0);
    push_prefix(0, 0, 4);
    push_prefix(15, 15, 15);

    // sizes below the minimum act as four
    write_board_size(5'd0);
    push_prefix(1, 3, 0);
    push_prefix(15, 15, 15);
    write_board_size(5'd3);
    push_prefix(2, 0, 3);

    write_board_size(5'd8);
    push_prefix(0, 4, 7);
    push_prefix(0, 0, 0);
    push_prefix(7, 7, 7);
    push_prefix(8, 0, 0);

    // largest board, directly and through an oversized value
    write_board_size(5'd16);
    push_prefix(0, 2, 4);
    write_board_size(5'd31);
    push_prefix(15, 13, 11);

    // block fills up behind a long output hold-off
    write_board_size(5'd12);
    hold_reqs++;
    add_random(16);

    write_board_size(5'd5);
    calm = 1'b1;
    add_random(16);

    write_board_size(5'd10);
    calm = 1'b0;
    add_random(16);

    write_board_size(5'd6);
    hold_reqs++;
    add_random(16);

    write_board_size(5'd9);
    add_random(8);

    write_board_size(5'd7);
    add_random(8);

    write_board_size(5'd13);
    add_random(6);

    write_board_size(5'd11);
    add_random(4);

    wait_idle();
    repeat (100) @(posedge clk);
    if (errors == 0 && count_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/nqpc_pkg.sv
rtl/core/nqpc_ctrl.sv
rtl/core/nqpc_datapath.sv
rtl/core/nqueens_prefix_counter_core.sv
tb/tb.sv
